@@ rtl/phid_pkg.sv @@
// Package for the palette hash ID block: payload and config types, ID byte packing.
package phid_pkg;

   localparam int PalEntries = 256;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 8;
   localparam int HashShift = 11;

   localparam logic [CsrIndexWidth-1:0] CsrBitsPerPixel    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPaletteBits     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrTransparentOn   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrFixupOn         = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrTransparentColor = 3'd4;

   localparam logic [23:0] BlackFix = 24'h040404;

   typedef struct packed {
      logic [31:0] entry_word;
      logic        last_entry;
   } phid_req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  mode_byte;
      logic [39:0] hash_code;
      logic [7:0]  trans_byte;
   } phid_rsp_type;

   typedef struct packed {
      logic [3:0] bits_per_pixel;
      logic [3:0] palette_bits;
      logic       transparent_on;
      logic       fixup_on;
      logic [7:0] transparent_color;
   } phid_cfg_type;

   typedef struct packed {
      logic        status;
      logic [31:0] hash;
   } phid_done_type;

   function automatic logic [7:0] id_low7(input logic [7:0] v);
      id_low7 = {1'b0, v[6:1], 1'b1};
   endfunction

   function automatic logic [39:0] build_hash_code(input logic [31:0] h);
      logic [7:0] b5;
      b5 = {h[7], 3'b000, h[24], h[16], h[8], h[0]};
      build_hash_code = {b5, id_low7(h[31:24]), id_low7(h[23:16]),
                         id_low7(h[15:8]), id_low7(h[7:0])};
   endfunction

endpackage

@@ rtl/phid_csr.sv @@
// Configuration registers of the palette hash ID block.
module phid_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [phid_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [phid_pkg::CsrDataWidth-1:0]   csr_data,
   output phid_pkg::phid_cfg_type              cfg
);

   phid_pkg::phid_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            phid_pkg::CsrBitsPerPixel:     cfg_in.bits_per_pixel = csr_data[3:0];
            phid_pkg::CsrPaletteBits:      cfg_in.palette_bits = csr_data[3:0];
            phid_pkg::CsrTransparentOn:    cfg_in.transparent_on = csr_data[0];
            phid_pkg::CsrFixupOn:          cfg_in.fixup_on = csr_data[0];
            phid_pkg::CsrTransparentColor: cfg_in.transparent_color = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bits_per_pixel <= 4'd8;
         cfg_ff.palette_bits <= 4'd8;
         cfg_ff.transparent_on <= 1'b0;
         cfg_ff.fixup_on <= 1'b0;
         cfg_ff.transparent_color <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/phid_hash.sv @@
// Input register, entry masking and fixup, and running hash of the palette hash ID block.
module phid_hash (
   input  logic                    clock,
   input  logic                    reset,
   input  phid_pkg::phid_cfg_type  cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  phid_pkg::phid_req_type  req_data,
   input  logic                    out_free,
   output logic                    done_load,
   output phid_pkg::phid_done_type done
);

   logic                   s1_valid_ff, s1_valid_in;
   phid_pkg::phid_req_type s1_data_ff;
   logic [31:0]            hash_ff, hash_in;
   logic [7:0]             index_ff, index_in;
   logic                   s1_move;
   logic [3:0]             count_bits;
   logic [8:0]             valid_count;
   logic [31:0]            entry;
   logic [31:0]            hash_sum;
   logic                   bad;

   assign s1_move = s1_valid_ff && (!s1_data_ff.last_entry || out_free);
   assign req_ready = !s1_valid_ff || s1_move;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_move);

   always_comb begin
      count_bits = (cfg.palette_bits > 4'd8) ? 4'd8 : cfg.palette_bits;
      valid_count = 9'd1 << count_bits;
      entry = s1_data_ff.entry_word;
      if ({1'b0, index_ff} >= valid_count ||
          32'(index_ff) >= 32'(phid_pkg::PalEntries)) begin
         entry = 32'd0;
      end
      if (cfg.fixup_on && cfg.transparent_on) begin
         if (index_ff == cfg.transparent_color) begin
            entry = {entry[31:24], 24'd0};
         end else if (entry[23:0] == 24'd0) begin
            entry = {entry[31:24], phid_pkg::BlackFix};
         end
      end
      hash_sum = hash_ff + (hash_ff >> phid_pkg::HashShift) + entry;
      bad = (cfg.palette_bits == 4'd0) || (cfg.palette_bits > 4'd8) ||
            (cfg.palette_bits > cfg.bits_per_pixel);
      hash_in = hash_ff;
      index_in = index_ff;
      if (s1_move) begin
         if (s1_data_ff.last_entry) begin
            hash_in = 32'd0;
            index_in = 8'd0;
         end else begin
            hash_in = hash_sum;
            index_in = index_ff + 8'd1;
         end
      end
   end

   assign done_load = s1_move && s1_data_ff.last_entry;
   assign done.status = bad;
   assign done.hash = hash_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hash_ff <= 32'd0;
         index_ff <= 8'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         hash_ff <= hash_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
   end

endmodule

@@ rtl/phid_out.sv @@
// Result register of the palette hash ID block: packs the seven-byte ID.
module phid_out (
   input  logic                    clock,
   input  logic                    reset,
   input  phid_pkg::phid_cfg_type  cfg,
   input  logic                    done_load,
   input  phid_pkg::phid_done_type done,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output phid_pkg::phid_rsp_type  rsp_data
);

   logic                   rsp_valid_ff, rsp_valid_in;
   phid_pkg::phid_rsp_type rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = done_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      rsp_data_in.status = done.status;
      if (done.status) begin
         rsp_data_in.mode_byte = 8'd0;
         rsp_data_in.hash_code = 40'd0;
         rsp_data_in.trans_byte = 8'd0;
      end else begin
         rsp_data_in.mode_byte = {cfg.transparent_on, 3'b000, cfg.bits_per_pixel};
         rsp_data_in.hash_code = phid_pkg::build_hash_code(done.hash);
         rsp_data_in.trans_byte = cfg.transparent_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ rtl/palette_hash_id_core.sv @@
// Top level of the palette hash ID block.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    phid_req_type (entry_word, last_entry)
//   rsp      out        rsp_valid/rsp_ready    phid_rsp_type (status, mode, hash, trans)
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle sustained while the result register can take a last entry.
// An entry is held in the input register, where it is masked, fixed up and folded
// into the hash; a last entry then loads the result register, which presents its ID.
// A last entry waits in the input register while the result register is full.
// Sync reset clears hash and entry position, sets default config; csr_ready always high.
module palette_hash_id_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  phid_pkg::phid_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output phid_pkg::phid_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [phid_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [phid_pkg::CsrDataWidth-1:0]   csr_data
);

   phid_pkg::phid_cfg_type  cfg;
   phid_pkg::phid_done_type done;
   logic                    done_load;
   logic                    out_free;

   phid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   phid_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .done_load (done_load),
      .done      (done)
   );

   phid_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .done_load (done_load),
      .done      (done),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for palette_hash_id_core: random palettes, shadow hash model, ID checks.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [phid_pkg::CsrIndexWidth-1:0] CsrUnused = 3'd5;
   localparam int unsigned SettleCycles = 8;

   logic                               clock;
   logic                               reset;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   phid_pkg::phid_req_type             req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   phid_pkg::phid_rsp_type             rsp_data;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [phid_pkg::CsrIndexWidth-1:0] csr_index;
   logic [phid_pkg::CsrDataWidth-1:0]  csr_data;

   phid_pkg::phid_req_type pending_entries[$];
   phid_pkg::phid_rsp_type expected_ids[$];

   phid_pkg::phid_cfg_type cfg_shadow = '{bits_per_pixel: 4'd8, palette_bits: 4'd8,
                                          default: '0};
   logic [31:0]  hash_acc = '0;
   logic [7:0]   entry_pos = '0;

   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   bit          calm;
   int          queued_count;
   int          accepted_count = 0;
   int          ids_checked = 0;
   int          error_ids = 0;
   int          settings_count;
   int          error_count = 0;

   palette_hash_id_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic logic [39:0] id_from_hash(input logic [31:0] h);
      logic [39:0] code;
      logic [31:0] folded;
      for (int k = 0; k < 4; k++) begin
         code[8*k +: 8] = 8'(((h >> (8*k)) | 32'h1) & 32'h7F);
      end
      folded = (h & 32'h81) | (((h >> 8) & 32'h81) << 1) |
               (((h >> 16) & 32'h81) << 2) | (((h >> 24) & 32'h81) << 3);
      code[39:32] = folded[7:0];
      return code;
   endfunction

   // fold one accepted entry into the shadow hash; a last entry yields an ID
   function automatic void fold_entry(input phid_pkg::phid_req_type item);
      logic [31:0]            word;
      int unsigned            span;
      logic                   invalid;
      phid_pkg::phid_rsp_type id;
      word = item.entry_word;
      span = 1 << ((cfg_shadow.palette_bits > 8) ? 8 : cfg_shadow.palette_bits);
      if (entry_pos >= span) word = '0;
      if (cfg_shadow.fixup_on && cfg_shadow.transparent_on) begin
         if (entry_pos == cfg_shadow.transparent_color) word[23:0] = '0;
         else if (word[23:0] == '0) word[23:0] = phid_pkg::BlackFix;
      end
      hash_acc = hash_acc + (hash_acc >> phid_pkg::HashShift) + word;
      entry_pos = entry_pos + 8'd1;
      if (item.last_entry) begin
         invalid = cfg_shadow.palette_bits == 0 || cfg_shadow.palette_bits > 8 ||
                   cfg_shadow.palette_bits > cfg_shadow.bits_per_pixel;
         id = '0;
         if (invalid) begin
            id.status = 1'b1;
         end else begin
            id.mode_byte  = {cfg_shadow.transparent_on, 3'b000, cfg_shadow.bits_per_pixel};
            id.hash_code  = id_from_hash(hash_acc);
            id.trans_byte = cfg_shadow.transparent_color;
         end
         expected_ids.push_back(id);
         hash_acc = '0;
         entry_pos = '0;
      end
   endfunction

   task automatic report_field(input string name, input logic [39:0] want, input logic [39:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_id(input phid_pkg::phid_rsp_type got);
      phid_pkg::phid_rsp_type want;
      if (expected_ids.size() == 0) begin
         $display("%0t: unexpected ID item %h", $time, got);
         error_count++;
      end else begin
         want = expected_ids.pop_front();
         report_field("status", 40'(want.status), 40'(got.status));
         report_field("mode_byte", 40'(want.mode_byte), 40'(got.mode_byte));
         report_field("hash_code", want.hash_code, got.hash_code);
         report_field("trans_byte", 40'(want.trans_byte), 40'(got.trans_byte));
         ids_checked++;
         if (want.status) error_ids++;
      end
   endtask

   // entry driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            fold_entry(req_data);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_entries.size() != 0) begin
               req_data <= pending_entries.pop_front();
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ID monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_id(rsp_data);
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            stall_left <= pick_gap();
         end
      end
   end

   // register shadow
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            phid_pkg::CsrBitsPerPixel:     cfg_shadow.bits_per_pixel = csr_data[3:0];
            phid_pkg::CsrPaletteBits:      cfg_shadow.palette_bits = csr_data[3:0];
            phid_pkg::CsrTransparentOn:    cfg_shadow.transparent_on = csr_data[0];
            phid_pkg::CsrFixupOn:          cfg_shadow.fixup_on = csr_data[0];
            phid_pkg::CsrTransparentColor: cfg_shadow.transparent_color = csr_data;
            default: ;
         endcase
      end
   end

   task automatic push_entry(input logic [31:0] word, input logic last);
      phid_pkg::phid_req_type item;
      item.entry_word = word;
      item.last_entry = last;
      pending_entries.push_back(item);
      queued_count++;
   endtask

   function automatic logic [31:0] rand_entry();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return {8'($urandom), 24'h0};
      if (r == 1) return '0;
      if (r == 2) return '1;
      return $urandom;
   endfunction

   task automatic queue_palette(input int len);
      for (int i = 0; i < len; i++) push_entry(rand_entry(), i == len - 1);
   endtask

   task automatic drain_all();
      while (accepted_count != queued_count || expected_ids.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [phid_pkg::CsrIndexWidth-1:0] idx,
                            input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [3:0] bpp, input logic [3:0] pb, input logic ton,
                                input logic fix, input logic [7:0] tc);
      drain_all();
      repeat (SettleCycles) @(posedge clock);
      write_reg(phid_pkg::CsrBitsPerPixel, {4'($urandom), bpp});
      write_reg(phid_pkg::CsrPaletteBits, {4'($urandom), pb});
      write_reg(phid_pkg::CsrTransparentOn, {7'($urandom), ton});
      write_reg(phid_pkg::CsrFixupOn, {7'($urandom), fix});
      write_reg(phid_pkg::CsrTransparentColor, tc);
      settings_count++;
   endtask

   initial begin
      logic [3:0] bpp;
      logic [3:0] pb;
      logic [7:0] tc;
      int         budget;
      int         len;
      int unsigned r;

      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      calm = 1'b0;
      queued_count = 0;
      settings_count = 1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero and all-ones entries, a short palette
      push_entry(32'h0000_0000, 1'b1);
      push_entry(32'hFFFF_FFFF, 1'b1);
      push_entry(32'h1234_5678, 1'b0);
      push_entry(32'hFFFF_FFFF, 1'b0);
      push_entry(32'hA500_0000, 1'b1);

      // smallest sizes with fixup: transparent index, black, masked entries
      apply_setting(4'd1, 4'd1, 1'b1, 1'b1, 8'd0);
      push_entry(32'hFF12_3456, 1'b0);
      push_entry(32'h8000_0000, 1'b0);
      push_entry(32'hFFFF_FFFF, 1'b0);
      push_entry(32'h0000_0001, 1'b1);

      // transparency without fixup, wide pixel depth in the mode byte
      apply_setting(4'd15, 4'd8, 1'b1, 1'b0, 8'hFF);
      push_entry(32'h0000_0000, 1'b1);

      // invalid size settings
      apply_setting(4'd8, 4'd9, 1'b0, 1'b0, 8'h00);
      push_entry(32'hDEAD_BEEF, 1'b1);
      apply_setting(4'd8, 4'd0, 1'b1, 1'b1, 8'h01);
      push_entry(32'h0102_0304, 1'b1);
      apply_setting(4'd4, 4'd5, 1'b0, 1'b1, 8'h80);
      push_entry(32'h7F00_0000, 1'b1);
      apply_setting(4'd0, 4'd1, 1'b0, 1'b0, 8'h00);
      drain_all();
      repeat (SettleCycles) @(posedge clock);
      write_reg(CsrUnused, 8'($urandom));
      push_entry(32'h0000_00FF, 1'b1);

      // one palette long enough for the position to wrap past the transparent index
      apply_setting(4'd8, 4'd8, 1'b1, 1'b1, 8'd2);
      queue_palette(300);

      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0) begin
            bpp = 4'd8;
            pb = 4'd8;
            tc = 8'd255;
         end else if (phase == 1) begin
            bpp = 4'd1;
            pb = 4'd1;
            tc = 8'd0;
         end else if ($urandom_range(0, 5) == 0) begin
            bpp = 4'($urandom);
            pb = 4'($urandom);
            tc = 8'($urandom);
         end else begin
            bpp = 4'($urandom_range(1, 8));
            pb = 4'($urandom_range(1, bpp));
            tc = $urandom_range(0, 1) ? 8'($urandom_range(0, (1 << pb) + 3)) : 8'($urandom);
         end
         apply_setting(bpp, pb, phase < 2 ? 1'b1 : 1'($urandom),
                       phase < 2 ? 1'b1 : 1'($urandom), tc);
         calm = (phase % 3 == 2);
         budget = 0;
         while (budget < 120) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 16);
            else if (r < 96) len = $urandom_range(17, 64);
            else len = $urandom_range(65, 260);
            queue_palette(len);
            budget += len;
            if ($urandom_range(0, 11) == 0) drain_all();
         end
      end

      drain_all();
      repeat (10) @(posedge clock);
      $display("%0d palette entries sent, %0d IDs checked (%0d with error status)",
               accepted_count, ids_checked, error_ids);
      $display("%0d register settings exercised", settings_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
